### design/ophal_pkg.sv
`default_nettype none

package ophal_pkg;

  localparam int FUNC_W        = 2;
  localparam int HANDLE_W      = 6;
  localparam int STATUS_W      = 2;
  localparam int POOL_SIZE_DEF = 64;

  // Request codes
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TRY   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

`default_nettype wire

### design/ophal_ram.sv
`default_nettype none

module ophal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/ophal_ctrl.sv
`default_nettype none

module ophal_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire ophal_pkg::dp_status_t dp_stat,
  output ophal_pkg::ctrl_cmd_t      cmd,
  output logic                      busy
);

  import ophal_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (dp_stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/ophal_dp.sv
`default_nettype none

module ophal_dp #(
  parameter int POOL_SIZE = ophal_pkg::POOL_SIZE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ophal_pkg::ctrl_cmd_t               cmd,
  input  wire logic [ophal_pkg::FUNC_W-1:0]       func,
  input  wire logic [ophal_pkg::HANDLE_W-1:0]     handle,
  output ophal_pkg::dp_status_t                   dp_stat,
  output logic                                    done,
  output logic      [ophal_pkg::HANDLE_W-1:0]     out_handle,
  output logic      [ophal_pkg::STATUS_W-1:0]     status
);

  import ophal_pkg::*;

  localparam int HW = $clog2(POOL_SIZE);
  localparam int CW = HW + 1;
  localparam logic [HW-1:0] LAST = HW'(POOL_SIZE - 1);

  logic [HW-1:0]       head;
  logic [HW-1:0]       tail;
  logic [CW-1:0]       count;
  logic [CW-1:0]       fresh;
  logic [HW-1:0]       clr_addr;
  logic [FUNC_W-1:0]   req_func;
  logic [HANDLE_W-1:0] req_handle;

  logic [HW+HANDLE_W-1:0] in_ext;
  logic [HW+HANDLE_W-1:0] req_ext;
  logic [HW+HANDLE_W-1:0] grant_ext;
  logic [HW-1:0]          in_idx;
  logic [HW-1:0]          req_idx;
  logic                   req_in_range;

  logic [HW-1:0] q_rdata;
  logic          held_rdata;
  logic          held_we;
  logic [HW-1:0] held_waddr;
  logic          held_wdata;

  logic                grant;
  logic [HW-1:0]       grant_idx;
  logic                pop;
  logic                fresh_take;
  logic                push;
  logic [HANDLE_W-1:0] res_handle;
  logic [STATUS_W-1:0] res_status;

  assign in_ext       = {{HW{1'b0}}, handle};
  assign req_ext      = {{HW{1'b0}}, req_handle};
  assign in_idx       = in_ext[HW-1:0];
  assign req_idx      = req_ext[HW-1:0];
  assign req_in_range = ({26'd0, req_handle} < 32'(POOL_SIZE));
  assign grant_ext    = {{HANDLE_W{1'b0}}, grant_idx};
  assign res_handle   = grant ? grant_ext[HANDLE_W-1:0] : '0;

  assign dp_stat.clear_last = (clr_addr == LAST);

  // Released handles, oldest first. The head entry is read every cycle, so it
  // is ready when the request is decided.
  ophal_ram #(
    .WIDTH (HW),
    .DEPTH (POOL_SIZE)
  ) u_queue (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata (req_idx),
    .raddr (head),
    .rdata (q_rdata)
  );

  // One bit per handle, set while held; swept to zero after reset.
  ophal_ram #(
    .WIDTH (1),
    .DEPTH (POOL_SIZE)
  ) u_held (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .raddr (in_idx),
    .rdata (held_rdata)
  );

  always_comb begin
    grant      = 1'b0;
    grant_idx  = q_rdata;
    pop        = 1'b0;
    fresh_take = 1'b0;
    push       = 1'b0;
    res_status = ST_OK;
    if (cmd.exec) begin
      case (req_func)
        FN_ALLOC: begin
          if (count != '0) begin
            grant = 1'b1;
            pop   = 1'b1;
          end else if (fresh < CW'(POOL_SIZE)) begin
            grant      = 1'b1;
            fresh_take = 1'b1;
            grant_idx  = fresh[HW-1:0];
          end else begin
            res_status = ST_NONE;
          end
        end
        FN_TRY: begin
          if (count != '0) begin
            grant = 1'b1;
            pop   = 1'b1;
          end else begin
            res_status = ST_NONE;
          end
        end
        FN_FREE: begin
          if (req_in_range && held_rdata && (count < CW'(POOL_SIZE))) begin
            push = 1'b1;
          end else begin
            res_status = ST_BADFREE;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    held_we    = cmd.clear | grant | push;
    held_wdata = grant;
    if (cmd.clear) begin
      held_waddr = clr_addr;
    end else if (grant) begin
      held_waddr = grant_idx;
    end else begin
      held_waddr = req_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      fresh    <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (pop) begin
        head  <= (head == LAST) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
      if (push) begin
        tail  <= (tail == LAST) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end
      if (fresh_take) begin
        fresh <= fresh + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_func   <= func;
      req_handle <= handle;
    end
    if (cmd.exec) begin
      out_handle <= res_handle;
      status     <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(POOL_SIZE))
    else $error("released queue count beyond pool size");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh <= CW'(POOL_SIZE))
    else $error("fresh handle counter beyond pool size");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec))
    else $error("result strobe without a decided request");

  a_fail_zero_handle: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (out_handle == '0))
    else $error("refused request carries a handle");

  a_no_pop_and_push: assert property (@(posedge clk) disable iff (rst)
    !(pop && push))
    else $error("queue read and written for one request");

endmodule

`default_nettype wire

### design/object_pool_handle_allocator.sv
// Channel   Ports                         Transfer
// request   start, func, handle           accepted when start is high and busy is low
// result    done, out_handle, status      valid for the single cycle in which done is high
//
// A request is accepted, then decided: the accepting cycle reads the released-handle queue
// head and the handle's held bit; the next cycle decides and, on success, writes the held
// bit and, for a free, the queue. The result shows the cycle after that, while the next
// request may already be taken. After reset the held bitmap is swept to zero, one entry a
// cycle, while busy is high. The receiver cannot stall; results are never held back.
`default_nettype none

module object_pool_handle_allocator #(
  parameter int POOL_SIZE = ophal_pkg::POOL_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ophal_pkg::FUNC_W-1:0]   func,
  input  wire logic [ophal_pkg::HANDLE_W-1:0] handle,
  output logic                                done,
  output logic      [ophal_pkg::HANDLE_W-1:0] out_handle,
  output logic      [ophal_pkg::STATUS_W-1:0] status
);

  import ophal_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_stat;

  ophal_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .dp_stat (dp_stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  ophal_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (func),
    .handle     (handle),
    .dp_stat    (dp_stat),
    .done       (done),
    .out_handle (out_handle),
    .status     (status)
  );

endmodule

`default_nettype wire
